// File: design/npcm_pkg.sv
`default_nettype none

package npcm_pkg;

  localparam int PALETTE_DEPTH = 256;

  localparam int COMP_W  = 8;
  localparam int ENTRY_W = 8;
  localparam int SIZE_W  = 9;
  localparam int COLOR_W = 3 * COMP_W;
  localparam int DIST_W  = 18;

  // Entries past the reach of entry_index can be neither written nor searched.
  localparam int NCELLS    = (PALETTE_DEPTH < (1 << ENTRY_W)) ? PALETTE_DEPTH
                                                              : (1 << ENTRY_W);
  localparam int CELL_ID_W = $clog2(NCELLS);
  localparam int LATENCY   = NCELLS + 2;

  localparam logic [SIZE_W-1:0]  SIZE_RESET      = SIZE_W'(256);
  localparam logic               KEY_EN_RESET    = 1'b1;
  localparam logic [COLOR_W-1:0] KEY_COLOR_RESET = 24'hff00ff;
  localparam logic [ENTRY_W-1:0] KEY_INDEX_RESET = 8'hff;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_MATCH = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_PALETTE_SIZE = 2'd0,
    REG_KEY_ENABLE   = 2'd1,
    REG_KEY_COLOR    = 2'd2,
    REG_KEY_INDEX    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic               is_match;
    logic               keyed;
    logic [ENTRY_W-1:0] entry_index;
    color_t             color;
  } token_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [ENTRY_W-1:0] index;
  } best_t;

endpackage

`default_nettype wire

// File: design/nearest_palette_color_match.sv
`default_nettype none

// Maps RGB pixels to palette indexes through a row of cells, one palette
// entry per cell. Every word, load or match, walks the row cell by cell,
// one register per cell: a load writes its entry when it reaches that
// cell, and a match picks up the distance to each entry on the way and
// keeps the nearest one, lowest index first on a tie. A new word is taken
// in every cycle and busy stays low. A match returns its result through
// the input register, every cell and the output register; a load returns
// nothing. The result is on color_index and was_keyed for the single cycle
// that done is high and cannot be held off. Registers must be written by
// the user only while no match is in flight; the block does not enforce it.
module nearest_palette_color_match
  import npcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [ENTRY_W-1:0] entry_index,
  input  logic [COMP_W-1:0]  red,
  input  logic [COMP_W-1:0]  green,
  input  logic [COMP_W-1:0]  blue,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [COLOR_W-1:0] wr_data,
  output logic               done,
  output logic [ENTRY_W-1:0] color_index,
  output logic               was_keyed
);

  logic [SIZE_W-1:0]  palette_size;
  logic               key_enable;
  logic [COLOR_W-1:0] key_color;
  logic [ENTRY_W-1:0] key_index;

  logic              accept;
  logic              valid_head;
  token_t            token_head;
  logic [NCELLS:0]   valid_c;
  token_t            token_c [NCELLS+1];
  logic [DIST_W-1:0] dist_c  [NCELLS+1];
  best_t             best_c  [NCELLS+1];
  best_t             best_last;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= SIZE_RESET;
      key_enable   <= KEY_EN_RESET;
      key_color    <= KEY_COLOR_RESET;
      key_index    <= KEY_INDEX_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_PALETTE_SIZE: palette_size <= wr_data[SIZE_W-1:0];
        REG_KEY_ENABLE:   key_enable   <= wr_data[0];
        REG_KEY_COLOR:    key_color    <= wr_data;
        REG_KEY_INDEX:    key_index    <= wr_data[ENTRY_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_head <= 1'b0;
    end else begin
      valid_head <= accept;
    end
  end

  always_ff @(posedge clk) begin
    token_head.is_match    <= (mode_t'(mode) == MODE_MATCH);
    token_head.keyed       <= key_enable && ({red, green, blue} == key_color);
    token_head.entry_index <= entry_index;
    token_head.color       <= '{red: red, green: green, blue: blue};
  end

  assign valid_c[0] = valid_head;
  assign token_c[0] = token_head;
  assign dist_c[0]  = '1;
  assign best_c[0]  = '{distance: '1, index: '0};

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    npcm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cell_id      (CELL_ID_W'(k)),
      .palette_size (palette_size),
      .valid_in     (valid_c[k]),
      .token_in     (token_c[k]),
      .dist_in      (dist_c[k]),
      .best_in      (best_c[k]),
      .valid_out    (valid_c[k+1]),
      .token_out    (token_c[k+1]),
      .dist_out     (dist_c[k+1]),
      .best_out     (best_c[k+1])
    );
  end

  // The last cell's distance still needs its comparison.
  always_comb begin
    if (dist_c[NCELLS] < best_c[NCELLS].distance) begin
      best_last = '{distance: dist_c[NCELLS], index: ENTRY_W'(NCELLS - 1)};
    end else begin
      best_last = best_c[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_c[NCELLS] && token_c[NCELLS].is_match;
    end
  end

  always_ff @(posedge clk) begin
    was_keyed   <= token_c[NCELLS].keyed;
    color_index <= token_c[NCELLS].keyed ? key_index : best_last.index;
  end

`ifndef SYNTHESIS
  a_match_returns: assert property (@(posedge clk) disable iff (rst)
    accept && mode_t'(mode) == MODE_MATCH |-> ##LATENCY done)
    else $error("match word did not return a result on time");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    accept && mode_t'(mode) == MODE_LOAD |-> ##LATENCY !done)
    else $error("load word returned a result");

  a_key_carried: assert property (@(posedge clk) disable iff (rst)
    accept && mode_t'(mode) == MODE_MATCH && key_enable && {red, green, blue} == key_color
    |-> ##LATENCY (done && was_keyed))
    else $error("keyed pixel lost its key flag");
`endif

endmodule

`default_nettype wire

// File: design/npcm_cell.sv
`default_nettype none

module npcm_cell
  import npcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CELL_ID_W-1:0] cell_id,
  input  logic [SIZE_W-1:0]    palette_size,
  input  logic                 valid_in,
  input  token_t               token_in,
  input  logic [DIST_W-1:0]    dist_in,
  input  best_t                best_in,
  output logic                 valid_out,
  output token_t               token_out,
  output logic [DIST_W-1:0]    dist_out,
  output best_t                best_out
);

  color_t             entry;
  logic [COMP_W-1:0]  diff_r, diff_g, diff_b;
  logic [2*COMP_W-1:0] sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]  entry_dist;
  logic [ENTRY_W-1:0] own_index;
  logic [ENTRY_W-1:0] prev_index;
  logic               searched;

  assign own_index  = ENTRY_W'(cell_id);
  assign prev_index = own_index - 1'b1;

  // A size of zero still searches entry zero.
  assign searched = ({1'b0, own_index} < palette_size) || (cell_id == '0);

  always_comb begin
    diff_r = (entry.red   >= token_in.color.red)   ? entry.red   - token_in.color.red
                                                   : token_in.color.red   - entry.red;
    diff_g = (entry.green >= token_in.color.green) ? entry.green - token_in.color.green
                                                   : token_in.color.green - entry.green;
    diff_b = (entry.blue  >= token_in.color.blue)  ? entry.blue  - token_in.color.blue
                                                   : token_in.color.blue  - entry.blue;
    sq_r = {{COMP_W{1'b0}}, diff_r} * {{COMP_W{1'b0}}, diff_r};
    sq_g = {{COMP_W{1'b0}}, diff_g} * {{COMP_W{1'b0}}, diff_g};
    sq_b = {{COMP_W{1'b0}}, diff_b} * {{COMP_W{1'b0}}, diff_b};
    entry_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  // A load word writes the entry as it passes, so words behind it see the
  // new color and words ahead of it never do.
  always_ff @(posedge clk) begin
    if (valid_in && !token_in.is_match && token_in.entry_index == own_index) begin
      entry <= token_in.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // The distance to this cell's entry is compared one cell later, which
  // keeps the squaring and the comparison in separate cycles.
  always_ff @(posedge clk) begin
    token_out <= token_in;
    dist_out  <= searched ? entry_dist : '1;
    if (dist_in < best_in.distance) begin
      best_out <= '{distance: dist_in, index: prev_index};
    end else begin
      best_out <= best_in;
    end
  end

endmodule

`default_nettype wire
